>>> rtl/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and codes of the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int DEF_WIDTH = 32;

    typedef enum logic [2:0] {
        MODE_NORM = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4,
        MODE_EQ   = 3'd5,
        MODE_LT   = 3'd6,
        MODE_NONE = 3'd7
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_OVF  = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] a_num;
        logic [31:0] a_den;
        logic [31:0] b_num;
        logic [30:0] b_den;
    } t_in_word;

    typedef struct packed {
        logic [31:0] res_num;
        logic [30:0] res_den;
        logic        truth;
        logic [1:0]  status;
    } t_out_word;

endpackage

>>> rtl/rau_if.sv
// ----------------------------------------------------------------------------
// rau_in_if / rau_out_if
// Valid/ready channels carrying one operand word and one result word.
// ----------------------------------------------------------------------------
interface rau_in_if import rau_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rau_out_if import rau_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rational_arithmetic_unit.sv
// Time per word is data dependent: each Euclid step and each exact divide
// runs on the shared divider, and the number of Euclid steps varies by operand.
// Throughput: one word at a time; the shared 1-bit-per-cycle divider sets it.
// Ready is high only in the idle state; the result register holds until taken.
// Reset (synchronous, active low) returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact fraction normalize/add/sub/mul/div/compare with GCD reduction.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WIDTH = DEF_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int RES_W = (WIDTH > 32) ? 32 : WIDTH;
    localparam logic [63:0] LIM = 64'd1 << (RES_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_MULD, S_GCD, S_GWAIT, S_DIVN, S_DNWAIT,
        S_DIVD, S_DDWAIT, S_NEXT, S_OUT
    } t_state;

    t_state      r_state;
    t_mode       r_mode;
    logic        r_phase;   // 0: reducing operands, 1: reducing result
    logic        r_an, r_bn, r_neg;
    logic [63:0] r_am, r_ad, r_bm, r_bd;
    logic [63:0] r_m, r_d, r_gx, r_gy, r_g;
    logic        r_opb;     // reducing b during operand phase
    logic        r_valid;
    t_out_word   r_res;     // word under construction
    t_out_word   r_out;

    logic        w_dstart, w_ddone;
    logic [63:0] w_dnd, w_dsr, w_q, w_r;
    logic [63:0] w_p0, w_p1;
    logic [31:0] w_ma, w_mb, w_mc, w_md;
    logic        w_xn, w_yn;
    logic [31:0] am_in, ad_in, bm_in;

    rau_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_dividend(w_dnd), .i_divisor(w_dsr),
        .o_done(w_ddone), .o_quot(w_q), .o_rem(w_r)
    );

    assign am_in = i_in.data.a_num[31] ? 32'd0 - i_in.data.a_num : i_in.data.a_num;
    assign ad_in = i_in.data.a_den[31] ? 32'd0 - i_in.data.a_den : i_in.data.a_den;
    assign bm_in = i_in.data.b_num[31] ? 32'd0 - i_in.data.b_num : i_in.data.b_num;

    // two 32x32 multipliers, registered; operands are reduced magnitudes
    always_comb begin
        w_ma = r_am[31:0]; w_mb = r_bd[31:0]; w_mc = r_bm[31:0]; w_md = r_ad[31:0];
        unique case (r_mode)
            MODE_MUL: begin w_mb = r_bm[31:0]; w_mc = r_ad[31:0]; w_md = r_bd[31:0]; end
            MODE_DIV: begin w_mc = r_ad[31:0]; w_md = r_bm[31:0]; end
            default: ;
        endcase
    end
    assign w_p0 = {32'd0, w_ma} * {32'd0, w_mb};
    assign w_p1 = {32'd0, w_mc} * {32'd0, w_md};
    assign w_xn = r_an && (r_m != 64'd0);
    assign w_yn = ((r_mode == MODE_SUB) ? !r_bn : r_bn) && (r_d != 64'd0);

    assign w_dstart = (r_state == S_GCD && r_gy != 64'd0) || r_state == S_DIVN
                   || r_state == S_DIVD;
    assign w_dnd = (r_state == S_GCD) ? r_gx : (r_state == S_DIVN) ? r_m : r_d;
    assign w_dsr = (r_state == S_GCD) ? r_gy : r_g;

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid) begin
                    r_mode  <= t_mode'(i_in.data.mode);
                    r_res   <= '{res_num: 32'd0, res_den: 31'd1, truth: 1'b0,
                                 status: ST_OK};
                    r_an    <= i_in.data.a_num[31] ^ i_in.data.a_den[31];
                    r_bn    <= i_in.data.b_num[31];
                    r_am    <= {32'd0, am_in};
                    r_ad    <= {32'd0, ad_in};
                    r_bm    <= {32'd0, bm_in};
                    r_bd    <= {33'd0, i_in.data.b_den};
                    r_m     <= {32'd0, am_in};
                    r_d     <= {32'd0, ad_in};
                    r_gx    <= {32'd0, am_in};
                    r_gy    <= {32'd0, ad_in};
                    r_phase <= 1'b0;
                    r_opb   <= 1'b0;
                    if (i_in.data.mode == MODE_NONE) r_state <= S_OUT;
                    else if (ad_in == 32'd0 || (i_in.data.mode != MODE_NORM
                             && i_in.data.b_den == 31'd0)) begin
                        r_res.status <= ST_ZERO;
                        r_state <= S_OUT;
                    end else r_state <= S_GCD;
                end
                S_GCD: begin
                    if (r_gy == 64'd0) begin
                        r_g <= r_gx;
                        r_state <= S_DIVN;
                    end else r_state <= S_GWAIT;
                end
                S_GWAIT: if (w_ddone) begin
                    r_gx <= r_gy;
                    r_gy <= w_r;
                    r_state <= S_GCD;
                end
                S_DIVN: r_state <= S_DNWAIT;
                S_DNWAIT: if (w_ddone) begin
                    r_m <= w_q;
                    r_state <= S_DIVD;
                end
                S_DIVD: r_state <= S_DDWAIT;
                S_DDWAIT: if (w_ddone) begin
                    r_d <= w_q;
                    r_state <= S_NEXT;
                end
                S_NEXT: begin
                    if (r_phase) begin
                        if (r_d > LIM - 64'd1 || (r_neg ? (r_m > LIM) : (r_m > LIM - 64'd1)))
                            r_res.status <= ST_OVF;
                        else begin
                            r_res.res_num <= r_neg ? 32'd0 - r_m[31:0] : r_m[31:0];
                            r_res.res_den <= r_d[30:0];
                        end
                        r_state <= S_OUT;
                    end else if (!r_opb) begin
                        r_am <= r_m; r_ad <= r_d;
                        if (r_m == 64'd0) r_an <= 1'b0;
                        if (r_mode == MODE_NORM) begin
                            r_neg <= r_an && (r_m != 64'd0);
                            r_phase <= 1'b1;
                            if (r_m == 64'd0) r_state <= S_OUT;
                            else begin
                                r_gx <= r_m; r_gy <= r_d; r_state <= S_GCD;
                            end
                        end else begin
                            r_opb <= 1'b1;
                            r_m <= r_bm; r_d <= r_bd; r_gx <= r_bm; r_gy <= r_bd;
                            r_state <= S_GCD;
                        end
                    end else begin
                        r_bm <= r_m; r_bd <= r_d;
                        if (r_m == 64'd0) r_bn <= 1'b0;
                        if (r_mode == MODE_DIV && r_m == 64'd0) begin
                            r_res.status <= ST_ZERO;
                            r_state <= S_OUT;
                        end else r_state <= S_MUL0;
                    end
                end
                S_MUL0: begin
                    r_m <= w_p0;   // x (or numerator product)
                    r_d <= w_p1;   // y (or denominator product)
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_phase <= 1'b1;
                    unique case (r_mode)
                        MODE_ADD, MODE_SUB: begin
                            if (w_xn == w_yn) begin
                                r_m <= r_m + r_d; r_neg <= w_xn;
                            end else if (r_m >= r_d) begin
                                r_m <= r_m - r_d; r_neg <= w_xn;
                            end else begin
                                r_m <= r_d - r_m; r_neg <= w_yn;
                            end
                            r_state <= S_MUL2;
                        end
                        MODE_MUL, MODE_DIV: begin
                            r_neg <= r_an ^ r_bn;
                            r_state <= (r_m == 64'd0) ? S_OUT : S_GCD;
                            r_gx <= r_m; r_gy <= r_d;
                        end
                        MODE_EQ: begin
                            r_res.truth <= (w_xn == w_yn) && (r_m == r_d);
                            r_state <= S_OUT;
                        end
                        MODE_LT: begin
                            priority if (w_xn != w_yn) r_res.truth <= w_xn;
                            else if (!w_xn) r_res.truth <= r_m < r_d;
                            else r_res.truth <= r_m > r_d;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_MUL2: begin
                    // denominator product ad*bd
                    r_d <= {32'd0, r_ad[31:0]} * {32'd0, r_bd[31:0]};
                    r_gx <= r_m;
                    r_state <= S_MULD;
                end
                S_MULD: begin
                    r_gy <= r_d;
                    r_state <= (r_m == 64'd0) ? S_OUT : S_GCD;
                end
                S_OUT: if (!r_valid || o_out.ready) begin
                    r_out   <= r_res;
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("accepted while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result dropped");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.res_den != 31'd0)
        else $error("zero denominator out");
endmodule

>>> rtl/rau_divider.sv
// ----------------------------------------------------------------------------
// rau_divider
// Restoring divider, one quotient bit per cycle, unsigned 64-bit operands.
// ----------------------------------------------------------------------------
module rau_divider import rau_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [63:0] i_divisor,
    output logic        o_done,
    output logic [63:0] o_quot,
    output logic [63:0] o_rem
);
    logic [63:0] r_quot;
    logic [64:0] r_rem;
    logic [63:0] r_div;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_sh;

    assign w_sh = {r_rem[63:0], r_quot[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd64;
                r_quot <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                if (w_sh >= {1'b0, r_div}) begin
                    r_rem <= w_sh - {1'b0, r_div};
                    r_quot <= {r_quot[62:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quot <= {r_quot[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem[63:0];
endmodule

>>> sim/rational_arithmetic_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_test
// Sends operand words (directed corner cases, then random mixes of small and
// full-range fractions) through the valid/ready channel with random gaps. A
// local fraction calculator predicts each result word. The results are
// checked field by field in order.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_test;
    import rau_pkg::*;

    localparam int   N_RANDOM = 700;
    localparam logic [63:0] RES_LIM = 64'd1 << 31;

    logic i_clk;
    logic i_rst_n;

    rau_in_if  in_ch ();
    rau_out_if out_ch ();

    rational_arithmetic_unit #(.WIDTH(DEF_WIDTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_in_word  operand_q[$];
    t_out_word result_q[$];
    int        n_mismatch;
    int        n_results;
    int        send_gap;
    int        take_gap;
    logic      take_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---- fraction calculator ----
    function automatic logic [63:0] euclid(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic logic [63:0] magnitude(logic [31:0] v);
        return v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
    endfunction

    function automatic t_out_word reduce_fit(bit neg, logic [63:0] mag, logic [63:0] den);
        t_out_word   r;
        logic [63:0] g;
        logic [63:0] n;
        r = '{res_num: '0, res_den: 31'd1, truth: 1'b0, status: ST_OK};
        if (mag == 0)
            return r;
        g = euclid(mag, den);
        mag = mag / g;
        den = den / g;
        if (den > RES_LIM - 1 || (neg ? (mag > RES_LIM) : (mag > RES_LIM - 1))) begin
            r.status = ST_OVF;
            return r;
        end
        n = neg ? (64'd0 - mag) : mag;
        r.res_num = n[31:0];
        r.res_den = den[30:0];
        return r;
    endfunction

    function automatic t_out_word fraction_result(t_in_word w);
        t_out_word   r;
        bit          an, bn, xn, yn;
        logic [63:0] am, ad, bm, bd, xm, ym, g;
        logic signed [66:0] sx, sy;
        r = '{res_num: '0, res_den: 31'd1, truth: 1'b0, status: ST_OK};
        if (t_mode'(w.mode) == MODE_NONE)
            return r;
        an = w.a_num[31];
        am = magnitude(w.a_num);
        ad = magnitude(w.a_den);
        bn = w.b_num[31];
        bm = magnitude(w.b_num);
        bd = {33'd0, w.b_den};
        if (ad == 0 || (t_mode'(w.mode) != MODE_NORM && bd == 0)) begin
            r.status = ST_ZERO;
            return r;
        end
        if (w.a_den[31])
            an = !an;
        g  = euclid(am, ad);
        am = am / g;
        ad = ad / g;
        if (am == 0)
            an = 1'b0;
        if (t_mode'(w.mode) != MODE_NORM) begin
            g  = euclid(bm, bd);
            bm = bm / g;
            bd = bd / g;
            if (bm == 0)
                bn = 1'b0;
        end
        case (t_mode'(w.mode))
            MODE_NORM: r = reduce_fit(an, am, ad);
            MODE_ADD, MODE_SUB: begin
                xn = an;
                xm = am * bd;
                yn = (t_mode'(w.mode) == MODE_SUB) ? !bn : bn;
                ym = bm * ad;
                if (xm == 0) xn = 1'b0;
                if (ym == 0) yn = 1'b0;
                if (xn == yn)
                    r = reduce_fit(xn, xm + ym, ad * bd);
                else if (xm >= ym)
                    r = reduce_fit(xn, xm - ym, ad * bd);
                else
                    r = reduce_fit(yn, ym - xm, ad * bd);
            end
            MODE_MUL: r = reduce_fit(an != bn, am * bm, ad * bd);
            MODE_DIV: begin
                if (bm == 0)
                    r.status = ST_ZERO;
                else
                    r = reduce_fit(an != bn, am * bd, ad * bm);
            end
            default: begin
                // cross-multiplied compare, exact at 67 bits
                sx = $signed({3'd0, am * bd});
                sy = $signed({3'd0, bm * ad});
                if (an) sx = -sx;
                if (bn) sy = -sy;
                r.truth = (t_mode'(w.mode) == MODE_EQ) ? (sx == sy) : (sx < sy);
            end
        endcase
        return r;
    endfunction

    // ---- stimulus helpers ----
    function automatic logic [31:0] pick_value(bit den);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return den ? $urandom_range(1, 24) : 32'($urandom_range(0, 48)) - 32'd24;
            4:          return den ? -32'($urandom_range(1, 24)) : 32'($urandom_range(0, 400)) * 32'd7;
            5:          return {1'b1, 31'd0} + 32'($urandom_range(0, 3));
            6:          return 32'h7fff_ffff - 32'($urandom_range(0, 3));
            7:          return 32'($urandom_range(1, 65535)) * 32'($urandom_range(1, 65535));
            default:    return $urandom;
        endcase
    endfunction

    function automatic t_in_word random_operand();
        t_in_word w;
        logic [31:0] v;
        w.mode  = ($urandom_range(0, 40) == 0) ? MODE_NONE : 3'($urandom_range(0, 6));
        w.a_num = pick_value(1'b0);
        w.a_den = ($urandom_range(0, 40) == 0) ? 32'd0 : pick_value(1'b1);
        w.b_num = ($urandom_range(0, 20) == 0) ? 32'd0 : pick_value(1'b0);
        v       = pick_value(1'b1);
        w.b_den = ($urandom_range(0, 40) == 0) ? 31'd0 : (v[30:0] == 0 ? 31'd1 : v[30:0]);
        return w;
    endfunction

    function automatic t_in_word operand(t_mode m, logic [31:0] an, logic [31:0] ad,
                                         logic [31:0] bn, logic [30:0] bd);
        t_in_word w;
        w.mode  = m;
        w.a_num = an;
        w.a_den = ad;
        w.b_num = bn;
        w.b_den = bd;
        return w;
    endfunction

    // ---- driver ----
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            send_gap    <= 0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                result_q.push_back(fraction_result(in_ch.data));
            if (send_gap != 0 || operand_q.size() == 0) begin
                in_ch.valid <= 1'b0;
                if (send_gap != 0)
                    send_gap <= send_gap - 1;
            end else begin
                in_ch.data  <= operand_q.pop_front();
                in_ch.valid <= 1'b1;
                // a stretch of back-to-back words in the middle of the run
                send_gap    <= (operand_q.size() inside {[200:300]}) ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // ---- monitor ----
    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            take_gap     <= 0;
            n_mismatch   <= 0;
            n_results    <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                n_results <= n_results + 1;
                if (result_q.size() == 0) begin
                    n_mismatch <= n_mismatch + 1;
                    if (n_mismatch < 10)
                        $display("unexpected result word %p", out_ch.data);
                end else begin
                    want = result_q.pop_front();
                    if (out_ch.data.res_num !== want.res_num ||
                        out_ch.data.res_den !== want.res_den ||
                        out_ch.data.truth   !== want.truth   ||
                        out_ch.data.status  !== want.status) begin
                        n_mismatch <= n_mismatch + 1;
                        if (n_mismatch < 10)
                            $display("mismatch: exp %0d/%0d t%0b s%0d, got %0d/%0d t%0b s%0d",
                                $signed(want.res_num), want.res_den, want.truth, want.status,
                                $signed(out_ch.data.res_num), out_ch.data.res_den,
                                out_ch.data.truth, out_ch.data.status);
                    end
                end
                take_gap <= (n_results inside {[400:500]}) ? 0 : $urandom_range(0, 6);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= (take_gap == 0) && !take_hold;
                if (take_gap != 0)
                    take_gap <= take_gap - 1;
            end
        end
    end

    // long receiver stall while the sender keeps offering words
    initial begin
        take_hold = 1'b0;
        wait (n_results >= 150);
        @(posedge i_clk);
        take_hold <= 1'b1;
        repeat (4000) @(posedge i_clk);
        take_hold <= 1'b0;
    end

    initial begin
        #1000ms;
        $display("rational_arithmetic_unit_test failed");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;

        // directed corners
        operand_q.push_back(operand(MODE_NORM, 32'd6, 32'd4, 32'd0, 31'd0));
        operand_q.push_back(operand(MODE_NORM, 32'd6, -32'd4, 32'd0, 31'd0));
        operand_q.push_back(operand(MODE_NORM, 32'h8000_0000, -32'd1, 32'd0, 31'd1));
        operand_q.push_back(operand(MODE_NORM, 32'h8000_0000, 32'd1, 32'd0, 31'd1));
        operand_q.push_back(operand(MODE_NORM, 32'd5, 32'h8000_0000, 32'd0, 31'd1));
        operand_q.push_back(operand(MODE_NORM, 32'd0, -32'd7, 32'd3, 31'd5));
        operand_q.push_back(operand(MODE_NORM, 32'd3, 32'd0, 32'd1, 31'd1));
        operand_q.push_back(operand(MODE_ADD, 32'd1, 32'd2, 32'd1, 31'd3));
        operand_q.push_back(operand(MODE_ADD, 32'h7fff_ffff, 32'd1, 32'd1, 31'd1));
        operand_q.push_back(operand(MODE_ADD, 32'd1, 32'd2, 32'd1, 31'd0));
        operand_q.push_back(operand(MODE_SUB, 32'd1, 32'd2, 32'd1, 31'd2));
        operand_q.push_back(operand(MODE_SUB, 32'h8000_0000, 32'd1, 32'd1, 31'd1));
        operand_q.push_back(operand(MODE_SUB, 32'd2, 32'd3, 32'd4, 31'd6));
        operand_q.push_back(operand(MODE_MUL, 32'd2, 32'd3, -32'd9, 31'd4));
        operand_q.push_back(operand(MODE_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 31'd1));
        operand_q.push_back(operand(MODE_MUL, 32'd1, 32'h7fff_ffff, 32'd1, 31'h7fff_ffff));
        operand_q.push_back(operand(MODE_DIV, 32'd3, 32'd4, 32'd0, 31'd5));
        operand_q.push_back(operand(MODE_DIV, -32'd3, 32'd4, 32'd6, 31'd5));
        operand_q.push_back(operand(MODE_DIV, 32'h8000_0000, 32'd1, -32'd1, 31'd1));
        operand_q.push_back(operand(MODE_EQ, 32'd2, 32'd4, 32'd3, 31'd6));
        operand_q.push_back(operand(MODE_EQ, 32'd2, -32'd4, 32'd3, 31'd6));
        operand_q.push_back(operand(MODE_LT, 32'd1, 32'd3, 32'd1, 31'd2));
        operand_q.push_back(operand(MODE_LT, 32'h8000_0000, -32'd1, 32'h7fff_ffff, 31'd1));
        operand_q.push_back(operand(MODE_LT, 32'd0, 32'd5, 32'd0, 31'd0));
        operand_q.push_back(operand(MODE_NONE, 32'hffff_ffff, 32'd0, 32'hffff_ffff,
                                    31'h7fff_ffff));
        for (int i = 0; i < N_RANDOM; i++)
            operand_q.push_back(random_operand());

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (operand_q.size() == 0 && !in_ch.valid && result_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (n_mismatch == 0)
            $display("rational_arithmetic_unit_test passed");
        else
            $display("rational_arithmetic_unit_test failed");
        $finish;
    end

endmodule

>>> rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_divider.sv
rtl/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_test.sv
